>>> hw/rtl/fome_pkg.sv
// ----------------------------------------------------------------------------
// fome_pkg: shared types and constants of the FAST order message encoder
// This package holds the field widths, the fixed FAST header bytes and the
// order record that travels between the input stage and the encoder.
// ----------------------------------------------------------------------------
package fome_pkg;

    localparam int unsigned SIZE_W  = 8;
    localparam int unsigned IDENT_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned GROUP_W = 7;

    // Fixed message header, byte 0 first.
    localparam logic [7:0] PMAP_BYTE     = 8'hFC;
    localparam logic [7:0] TEMPLATE_BYTE = 8'h81;
    localparam logic [7:0] EXPONENT_BYTE = 8'h80;
    localparam logic [7:0] PRICE_BYTE    = 8'h81;

    // Leading byte of a two-byte size field.
    localparam logic [7:0] SIZE_HIGH_BYTE = 8'h01;

    // Stop bit that closes a stop-bit encoded field, and the data bits of a group.
    localparam logic [7:0] STOP_MARK  = 8'h80;
    localparam logic [7:0] GROUP_MASK = 8'h7F;

    typedef struct packed {
        logic [SIZE_W-1:0]  order_size;
        logic [IDENT_W-1:0] order_ident;
        logic [KIND_W-1:0]  order_kind;
    } order_t;

endpackage

>>> hw/rtl/fome_if.sv
// ----------------------------------------------------------------------------
// fome_if: valid/ready channels of the FAST order message encoder
// fome_order_if carries one order per transfer, fome_msg_if carries one
// encoded message, packed into two 64-bit words, per transfer.
// ----------------------------------------------------------------------------
interface fome_order_if;
    logic                          valid;
    logic                          ready;
    logic [fome_pkg::SIZE_W-1:0]   order_size;
    logic [fome_pkg::IDENT_W-1:0]  order_ident;
    logic [fome_pkg::KIND_W-1:0]   order_kind;

    modport source (output valid, output order_size, output order_ident,
                    output order_kind, input ready);
    modport sink   (input valid, input order_size, input order_ident,
                    input order_kind, output ready);
endinterface

interface fome_msg_if;
    logic                         valid;
    logic                         ready;
    logic [fome_pkg::WORD_W-1:0]  low_word;
    logic [fome_pkg::WORD_W-1:0]  high_word;

    modport source (output valid, output low_word, output high_word, input ready);
    modport sink   (input valid, input low_word, input high_word, output ready);
endinterface

>>> hw/rtl/fome_encode.sv
// ----------------------------------------------------------------------------
// fome_encode: stop-bit encoding of one order
// Builds the message bytes for one registered order: fixed header, size in
// one or two bytes, identifier groups with leading zero groups dropped, and
// the kind byte. Bytes past the end of the message are zero.
// ----------------------------------------------------------------------------
module fome_encode (
    input  fome_pkg::order_t              ord,
    output logic [fome_pkg::WORD_W-1:0]   low_word,
    output logic [fome_pkg::WORD_W-1:0]   high_word
);

    logic [6:0]   grp [5];
    logic [2:0]   n_groups;
    logic [2:0]   id_pos;
    logic [3:0]   kind_pos;
    logic [15:0]  size_bytes;
    logic [39:0]  id_full;
    logic [39:0]  id_seq;
    logic [7:0]   kind_byte;
    logic [127:0] msg;

    always_comb
    begin
        // Identifier groups, least significant first; the top group has 4 bits.
        grp[0] = ord.order_ident[6:0];
        grp[1] = ord.order_ident[13:7];
        grp[2] = ord.order_ident[20:14];
        grp[3] = ord.order_ident[27:21];
        grp[4] = {3'b000, ord.order_ident[31:28]};

        priority if (grp[4] != 7'd0) n_groups = 3'd5;
        else if (grp[3] != 7'd0)     n_groups = 3'd4;
        else if (grp[2] != 7'd0)     n_groups = 3'd3;
        else if (grp[1] != 7'd0)     n_groups = 3'd2;
        else                         n_groups = 3'd1;

        // A size with its top bit set spills into a leading byte.
        if (ord.order_size[7])
        begin
            size_bytes = {fome_pkg::STOP_MARK | {1'b0, ord.order_size[6:0]},
                          fome_pkg::SIZE_HIGH_BYTE};
            id_pos     = 3'd6;
        end
        else
        begin
            size_bytes = {8'h00, fome_pkg::STOP_MARK | ord.order_size};
            id_pos     = 3'd5;
        end

        // All five groups, most significant in the lowest byte, then drop the
        // suppressed leading groups by shifting them out.
        id_full = {fome_pkg::STOP_MARK | {1'b0, grp[0]},
                   1'b0, grp[1], 1'b0, grp[2], 1'b0, grp[3], 1'b0, grp[4]};
        id_seq  = id_full >> {3'(3'd5 - n_groups), 3'b000};

        kind_byte = fome_pkg::STOP_MARK | {5'b00000, ord.order_kind};
        kind_pos  = {1'b0, id_pos} + {1'b0, n_groups};

        msg = {96'd0, fome_pkg::PRICE_BYTE, fome_pkg::EXPONENT_BYTE,
               fome_pkg::TEMPLATE_BYTE, fome_pkg::PMAP_BYTE}
            | ({112'd0, size_bytes} << 32)
            | ({88'd0, id_seq} << {id_pos, 3'b000})
            | ({120'd0, kind_byte} << {kind_pos, 3'b000});

        low_word  = msg[63:0];
        high_word = msg[127:64];
    end

endmodule

>>> hw/rtl/fast_order_message_encoder_top.sv
// ----------------------------------------------------------------------------
// fast_order_message_encoder_top: FAST stop-bit order message encoder
// Registers one order, encodes it in a single combinational pass and holds
// the finished message in an output register until it is taken.
// ----------------------------------------------------------------------------
// Each order transfer on the order channel yields exactly one message
// transfer on the message channel, in order. The block sustains one order per
// clock cycle as long as the message channel is ready: the order is captured
// in an input register, the encoder turns it into the message bytes in one
// pass, and the result lands in an output register, where the message becomes
// valid. The output register decouples the two sides: while a message waits
// to be taken, the next order can still be captured in the input register,
// and the order channel only stalls once both registers are full and the
// message channel is not ready. The message is byte 0 first in bits 7:0 of
// low_word, bytes 8 to 15 in high_word, and every byte past the end of the
// message (at least bytes 12 to 15) is zero. There is no configuration and no
// state carried from one order to the next.
module fast_order_message_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    fome_order_if.sink  order,
    fome_msg_if.source  message
);

    // Input stage.
    logic                               in_valid_reg;
    logic                               in_valid_next;
    fome_pkg::order_t                   ord_reg;

    // Output stage.
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [fome_pkg::WORD_W-1:0]        low_reg;
    logic [fome_pkg::WORD_W-1:0]        high_reg;

    logic [fome_pkg::WORD_W-1:0]        enc_low;
    logic [fome_pkg::WORD_W-1:0]        enc_high;

    logic                               out_load;
    logic                               in_take;

    // The output register can take a new message when it is empty or its
    // current message is leaving in this cycle.
    assign out_load      = in_valid_reg && (!out_valid_reg || message.ready);
    assign order.ready   = !in_valid_reg || !out_valid_reg || message.ready;
    assign in_take       = order.valid && order.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (message.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ord_reg.order_size  <= order.order_size;
            ord_reg.order_ident <= order.order_ident;
            ord_reg.order_kind  <= order.order_kind;
        end
        if (out_load)
        begin
            low_reg  <= enc_low;
            high_reg <= enc_high;
        end
    end

    fome_encode u_encode (
        .ord       (ord_reg),
        .low_word  (enc_low),
        .high_word (enc_high)
    );

    assign message.valid     = out_valid_reg;
    assign message.low_word  = low_reg;
    assign message.high_word = high_reg;

endmodule

>>> hw/rtl/fome_checker.sv
// ----------------------------------------------------------------------------
// fome_checker: port-level checks of the FAST order message encoder
// Watches the order and message channels of the top level and flags
// messages that break the fixed framing or the buffering behavior.
// ----------------------------------------------------------------------------
module fome_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          order_ready,
    input logic                          msg_valid,
    input logic                          msg_ready,
    input logic [fome_pkg::WORD_W-1:0]   low_word,
    input logic [fome_pkg::WORD_W-1:0]   high_word
);

    // The message channel is quiet while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !msg_valid)
        else $error("message valid during reset");

    // A stalled message stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid && $stable(low_word) && $stable(high_word))
        else $error("stalled message changed");

    // Every message opens with the fixed four header bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid |-> low_word[31:0] == {fome_pkg::PRICE_BYTE, fome_pkg::EXPONENT_BYTE,
                                         fome_pkg::TEMPLATE_BYTE, fome_pkg::PMAP_BYTE})
        else $error("message header bytes wrong");

    // A message is at most twelve bytes long, so bytes 12 to 15 are padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid |-> high_word[63:32] == 32'd0)
        else $error("padding bytes not zero");

    // With the output register empty the block always takes an order.
    assert property (@(posedge clk) disable iff (!rst_n)
        !msg_valid |-> order_ready)
        else $error("order stalled with empty output");

endmodule

bind fast_order_message_encoder_top fome_checker u_fome_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .order_ready (order.ready),
    .msg_valid   (message.valid),
    .msg_ready   (message.ready),
    .low_word    (message.low_word),
    .high_word   (message.high_word)
);

>>> tb/sv/fome_msg_checker.sv
// ----------------------------------------------------------------------------
// fome_msg_checker: message predictor and scoreboard for the order encoder
// Watches both channels of the encoder, works out the expected FAST message
// for every order transfer and compares each message transfer against it.
// ----------------------------------------------------------------------------
module fome_msg_checker (
    input  logic        clk,
    input  logic        rst_n,
    fome_order_if       order_ch,
    fome_msg_if         msg_ch,
    output int unsigned err_count,
    output int unsigned pending
);
    import fome_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] high_word;
        logic [WORD_W-1:0] low_word;
    } msg_words_t;

    msg_words_t  expected_msgs [$];
    int unsigned msg_index;

    // Builds the stop-bit encoded message of one order, byte 0 first.
    function automatic msg_words_t encode_order(input logic [SIZE_W-1:0]  sz,
                                                input logic [IDENT_W-1:0] ident,
                                                input logic [KIND_W-1:0]  kind);
        logic [7:0]   msg_bytes [16];
        int           pos;
        bit           leading_done;
        logic [6:0]   grp;
        msg_words_t   words;
        for (int i = 0; i < 16; i++)
        begin
            msg_bytes[i] = 8'h00;
        end
        msg_bytes[0] = PMAP_BYTE;
        msg_bytes[1] = TEMPLATE_BYTE;
        msg_bytes[2] = EXPONENT_BYTE;
        msg_bytes[3] = PRICE_BYTE;
        pos = 4;
        if (sz[7])
        begin
            msg_bytes[pos] = SIZE_HIGH_BYTE;
            pos++;
        end
        msg_bytes[pos] = STOP_MARK | {1'b0, sz[6:0]};
        pos++;
        // Upper groups are skipped until the first nonzero one.
        leading_done = 1'b0;
        for (int g = 4; g >= 1; g--)
        begin
            grp = 7'(ident >> (GROUP_W * g));
            if (grp != 7'd0 || leading_done)
            begin
                msg_bytes[pos] = {1'b0, grp};
                pos++;
                leading_done = 1'b1;
            end
        end
        msg_bytes[pos] = STOP_MARK | {1'b0, ident[6:0]};
        pos++;
        msg_bytes[pos] = STOP_MARK | {5'b0, kind};
        for (int b = 0; b < 8; b++)
        begin
            words.low_word[8*b +: 8]  = msg_bytes[b];
            words.high_word[8*b +: 8] = msg_bytes[b+8];
        end
        return words;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        err_count++;
        $display("MISMATCH message %0d %s: expected %016h got %016h",
                 msg_index, what, want, got);
    endtask

    initial
    begin
        err_count = 0;
        pending   = 0;
        msg_index = 0;
    end

    always @(posedge clk)
    begin
        msg_words_t want;
        if (rst_n)
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                if (expected_msgs.size() == 0)
                begin
                    report_mismatch("with no order pending", '0, msg_ch.low_word);
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    if (msg_ch.low_word !== want.low_word)
                    begin
                        report_mismatch("low_word", want.low_word, msg_ch.low_word);
                    end
                    if (msg_ch.high_word !== want.high_word)
                    begin
                        report_mismatch("high_word", want.high_word, msg_ch.high_word);
                    end
                end
                msg_index++;
            end
            if (order_ch.valid && order_ch.ready)
            begin
                expected_msgs.push_back(encode_order(order_ch.order_size,
                                                     order_ch.order_ident,
                                                     order_ch.order_kind));
            end
            pending = expected_msgs.size();
        end
    end

endmodule

>>> tb/sv/fast_order_message_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// fast_order_message_encoder_top_tb: testbench of the FAST order encoder
// Sends directed and random orders through the encoder with bursty input and
// a stalling output, and lets the checker compare every encoded message.
// ----------------------------------------------------------------------------
module fast_order_message_encoder_top_tb;
    import fome_pkg::*;

    // Number of random orders after the directed ones.
    localparam int RANDOM_ORDERS = 1930;
    // Orders sent before the receiver goes into its long hold-off.
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_CYCLES = 120;

    logic        clk;
    logic        rst_n;
    logic        order_taken;
    int unsigned err_count;
    int unsigned pending;
    int          sent_count;
    int          burst_left;

    fome_order_if order_ch ();
    fome_msg_if   msg_ch ();

    fast_order_message_encoder_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .order   (order_ch),
        .message (msg_ch)
    );

    fome_msg_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .order_ch  (order_ch),
        .msg_ch    (msg_ch),
        .err_count (err_count),
        .pending   (pending)
    );

    // Free-running clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The order handshake is captured at the rising edge by a nonblocking
    // assignment, so the driver can look at it from the falling edge without
    // depending on the order of processes inside the rising-edge time step.
    always @(posedge clk)
    begin
        order_taken <= order_ch.valid && order_ch.ready;
    end

    // Offers one order and holds it until a transfer takes it. Orders come in
    // bursts of random length; between bursts the sender may pause with valid
    // low, and roughly half the bursts follow each other with no gap, so
    // stretches of back-to-back orders occur as well.
    task automatic send_order(input logic [SIZE_W-1:0]  sz,
                              input logic [IDENT_W-1:0] ident,
                              input logic [KIND_W-1:0]  kind);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 1)
            begin
                order_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        order_ch.valid       <= 1'b1;
        order_ch.order_size  <= sz;
        order_ch.order_ident <= ident;
        order_ch.order_kind  <= kind;
        do
        begin
            @(negedge clk);
        end
        while (!order_taken);
        burst_left--;
        sent_count++;
    endtask

    // Directed orders cover both size encodings at their edges, the zero
    // identifier, every group boundary of the identifier, the full 32-bit
    // identifier and every order kind.
    logic [IDENT_W-1:0] dir_ident [16] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_007F, 32'h0000_0080,
        32'h0000_3FFF, 32'h0000_4000, 32'h001F_FFFF, 32'h0020_0000,
        32'h0FFF_FFFF, 32'h1000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h7F00_0001
    };
    logic [SIZE_W-1:0] dir_size [16] = '{
        8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h81, 8'h40, 8'hC0,
        8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'h7F
    };

    // Stimulus and verdict.
    initial
    begin
        logic [IDENT_W-1:0] ident;
        int                 nbits;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        order_taken          = 1'b0;
        order_ch.valid       = 1'b0;
        order_ch.order_size  = '0;
        order_ch.order_ident = '0;
        order_ch.order_kind  = '0;
        sent_count           = 0;
        burst_left           = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 16; i++)
        begin
            send_order(dir_size[i], dir_ident[i], KIND_W'(i));
        end

        // Random orders. The identifier width is drawn first so that every
        // number of 7-bit groups, the zero identifier included, shows up often.
        for (int i = 0; i < RANDOM_ORDERS; i++)
        begin
            nbits = $urandom_range(0, IDENT_W);
            ident = $urandom;
            if (nbits < IDENT_W)
            begin
                ident = ident & ((32'h1 << nbits) - 32'h1);
            end
            send_order(SIZE_W'($urandom_range(0, 255)), ident,
                       KIND_W'($urandom_range(0, 7)));
        end
        order_ch.valid <= 1'b0;

        // Drain: wait for every expected message, then let the clock run on so
        // that any stray extra message would be seen.
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver. It works through phases of random length, each with its own
    // stall pattern: always ready, a coin toss, mostly stalled, or a rotating
    // bit pattern. Once, after enough orders have gone in, it holds off for a
    // long stretch while the sender keeps offering orders, so both registers
    // of the block fill up and the order channel has to stall.
    initial
    begin
        bit         held;
        int         mode;
        int         phase_len;
        logic [7:0] stall_pattern;
        held          = 1'b0;
        msg_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent_count >= HOLD_AFTER)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    msg_ch.ready <= 1'b0;
                end
            end
            mode          = $urandom_range(0, 3);
            phase_len     = $urandom_range(10, 150);
            stall_pattern = 8'($urandom);
            repeat (phase_len)
            begin
                @(negedge clk);
                case (mode)
                    0: msg_ch.ready <= 1'b1;
                    1: msg_ch.ready <= 1'($urandom_range(0, 1));
                    2: msg_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        msg_ch.ready  <= stall_pattern[0];
                        stall_pattern  = {stall_pattern[0], stall_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
